// ===== rtl/core/rcsp_pkg.sv =====
// Shared types, widths and codes for the rectangle clip, scale and pad block.
`default_nettype none
package rcsp_pkg;

	localparam int COORD_W = 24;
	localparam int SIZE_W  = 23;
	localparam int PAD_W   = 16;
	localparam int PROD_W  = 2 * SIZE_W;
	localparam int IDX_W   = 3;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_VISIBLE = 2'd1,
		ST_INVALID     = 2'd2
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_REGION_X = 3'd0,
		REG_REGION_Y = 3'd1,
		REG_REGION_W = 3'd2,
		REG_REGION_H = 3'd3,
		REG_SOURCE_W = 3'd4,
		REG_SOURCE_H = 3'd5,
		REG_PAD      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rect_x;
		logic signed [COORD_W-1:0] rect_y;
		logic signed [COORD_W-1:0] rect_w;
		logic signed [COORD_W-1:0] rect_h;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic [SIZE_W-1:0] out_x;
		logic [SIZE_W-1:0] out_y;
		logic [SIZE_W-1:0] out_w;
		logic [SIZE_W-1:0] out_h;
	} out_t;

	// Control flags that travel beside the arithmetic through every stage.
	typedef struct packed {
		logic vld;
		logic bad;
		logic vis_x;
		logic vis_y;
	} meta_t;

endpackage
`default_nettype wire

// ===== rtl/core/rect_clip_scale_pad.sv =====
// Top level: clips a screen rectangle to the capture region and maps it to source pixels.
//
// Usage:
// - Configuration: write registers through cfg_valid/cfg_ready with cfg_index and
//   cfg_data while no transaction is in flight; cfg_ready is always high.
// - Input: one rectangle per in_valid/in_ready transaction on in_data.
// - Output: one result per input on out_data, in order, under out_valid/out_ready.
// Pipeline: one clip stage, one multiply stage, 23 divider stages (one quotient
// bit each) and the pad/clamp output register.
// Throughput: one rectangle per cycle unless the output stalls. The whole pipeline
// advances together whenever the output register is empty or being taken.
// Stall: while a result waits with out_ready low, in_ready drops and every stage
// holds; nothing is lost or repeated.
// Reset: arst_n clears all valid bits and all configuration registers to zero,
// so results are invalid until the sizes are written.
`default_nettype none
module rect_clip_scale_pad import rcsp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_t                  out_data
);

	logic signed [COORD_W-1:0] region_x_q, region_y_q;
	logic [SIZE_W-1:0]         region_w_q, region_h_q, source_w_q, source_h_q;
	logic [PAD_W-1:0]          pad_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_x_q <= '0;
			region_y_q <= '0;
			region_w_q <= '0;
			region_h_q <= '0;
			source_w_q <= '0;
			source_h_q <= '0;
			pad_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_REGION_X: region_x_q <= cfg_data;
				REG_REGION_Y: region_y_q <= cfg_data;
				REG_REGION_W: region_w_q <= cfg_data[SIZE_W-1:0];
				REG_REGION_H: region_h_q <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_W: source_w_q <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_H: source_h_q <= cfg_data[SIZE_W-1:0];
				REG_PAD:      pad_q      <= cfg_data[PAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	out_t out_data_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Clip one axis against the region; offsets are only meaningful when visible.
	typedef struct packed {
		logic              vis;
		logic [SIZE_W-1:0] off0;
		logic [SIZE_W-1:0] off1;
	} clip_t;

	function automatic clip_t clip_axis(logic signed [COORD_W-1:0] pos,
			logic signed [COORD_W-1:0] len, logic signed [COORD_W-1:0] rpos,
			logic [SIZE_W-1:0] rlen);
		logic signed [COORD_W:0]   e;
		logic signed [COORD_W:0]   r1;
		logic signed [COORD_W-1:0] a0;
		logic signed [COORD_W:0]   a1;
		logic signed [COORD_W+1:0] d0;
		logic signed [COORD_W+1:0] d1;
		clip_t res;
		e  = {pos[COORD_W-1], pos} + {len[COORD_W-1], len};
		r1 = {rpos[COORD_W-1], rpos} + $signed({2'b00, rlen});
		a0 = (pos > rpos) ? pos : rpos;
		a1 = (e < r1) ? e : r1;
		d0 = {{2{a0[COORD_W-1]}}, a0} - {{2{rpos[COORD_W-1]}}, rpos};
		d1 = {a1[COORD_W], a1} - {{2{rpos[COORD_W-1]}}, rpos};
		res.vis  = a1 > $signed({a0[COORD_W-1], a0});
		res.off0 = d0[SIZE_W-1:0];
		res.off1 = d1[SIZE_W-1:0];
		return res;
	endfunction

	// Stage 1: clip.
	meta_t meta_s1;
	clip_t cx_s1, cy_s1;
	clip_t cx, cy;

	assign cx = clip_axis(in_data.rect_x, in_data.rect_w, region_x_q, region_w_q);
	assign cy = clip_axis(in_data.rect_y, in_data.rect_h, region_y_q, region_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1.vld   <= in_valid;
			meta_s1.bad   <= (region_w_q == '0) || (region_h_q == '0) ||
				(source_w_q == '0) || (source_h_q == '0) ||
				in_data.rect_w[COORD_W-1] || in_data.rect_h[COORD_W-1];
			meta_s1.vis_x <= cx.vis;
			meta_s1.vis_y <= cy.vis;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= cx;
			cy_s1 <= cy;
		end
	end

	// Stage 2: scale offsets by the source size.
	meta_t meta_s2;
	logic [PROD_W-1:0] px0_s2, px1_s2, py0_s2, py1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else if (en) begin
			meta_s2 <= meta_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s2 <= cx_s1.off0 * source_w_q;
			px1_s2 <= cx_s1.off1 * source_w_q;
			py0_s2 <= cy_s1.off0 * source_h_q;
			py1_s2 <= cy_s1.off1 * source_h_q;
		end
	end

	// Divider stages: divide by the region size.
	logic [SIZE_W-1:0] qx0, qx1, qy0, qy1;

	rcsp_div u_div_x0 (.clk(clk), .en(en), .num(px0_s2), .den(region_w_q), .quo(qx0));
	rcsp_div u_div_x1 (.clk(clk), .en(en), .num(px1_s2), .den(region_w_q), .quo(qx1));
	rcsp_div u_div_y0 (.clk(clk), .en(en), .num(py0_s2), .den(region_h_q), .quo(qy0));
	rcsp_div u_div_y1 (.clk(clk), .en(en), .num(py1_s2), .den(region_h_q), .quo(qy1));

	meta_t meta_d_s [1:SIZE_W];

	for (genvar k = 1; k <= SIZE_W; k++) begin : g_meta
		meta_t meta_prev;

		if (k == 1) begin : g_first
			assign meta_prev = meta_s2;
		end else begin : g_next
			assign meta_prev = meta_d_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_d_s[k] <= '0;
			end else if (en) begin
				meta_d_s[k] <= meta_prev;
			end
		end
	end

	// Output stage: pad, clamp to the source and form the status.
	typedef struct packed {
		logic              vis;
		logic [SIZE_W-1:0] o0;
		logic [SIZE_W-1:0] olen;
	} span_t;

	function automatic span_t pad_clamp(logic [SIZE_W-1:0] q0, logic [SIZE_W-1:0] q1,
			logic [PAD_W-1:0] pv, logic [SIZE_W-1:0] src);
		logic [SIZE_W+1:0] lo;
		logic [SIZE_W:0]   hi;
		logic [SIZE_W-1:0] lo_c;
		logic [SIZE_W-1:0] hi_c;
		span_t res;
		lo   = {2'b00, q0} - {{(SIZE_W+2-PAD_W){1'b0}}, pv};
		hi   = {1'b0, q1} + {{(SIZE_W+1-PAD_W){1'b0}}, pv};
		lo_c = lo[SIZE_W+1] ? '0 : lo[SIZE_W-1:0];
		hi_c = (hi > {1'b0, src}) ? src : hi[SIZE_W-1:0];
		res.vis  = hi_c > lo_c;
		res.o0   = lo_c;
		res.olen = hi_c - lo_c;
		return res;
	endfunction

	meta_t meta_last;
	span_t sx, sy;
	out_t  res;

	assign meta_last = meta_d_s[SIZE_W];
	assign sx = pad_clamp(qx0, qx1, pad_q, source_w_q);
	assign sy = pad_clamp(qy0, qy1, pad_q, source_h_q);

	always_comb begin
		res = '0;
		if (meta_last.bad) begin
			res.status = ST_INVALID;
		end else if (meta_last.vis_x && meta_last.vis_y && sx.vis && sy.vis) begin
			res.status = ST_OK;
			res.out_x  = sx.o0;
			res.out_y  = sy.o0;
			res.out_w  = sx.olen;
			res.out_h  = sy.olen;
		end else begin
			res.status = ST_NOT_VISIBLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= meta_last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.out_x == '0 && out_data.out_y == '0 &&
			out_data.out_w == '0 && out_data.out_h == '0)
		else $error("non-ok result carries a nonzero rectangle");

	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |->
			out_data.out_w != '0 && out_data.out_h != '0)
		else $error("ok result has an empty extent");

	a_ok_inside_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |->
			({1'b0, out_data.out_x} + {1'b0, out_data.out_w}) <= {1'b0, source_w_q} &&
			({1'b0, out_data.out_y} + {1'b0, out_data.out_h}) <= {1'b0, source_h_q})
		else $error("ok result extends past the source bounds");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rcsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rcsp_div import rcsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [PROD_W-1:0] num,
	input  wire logic [SIZE_W-1:0] den,
	output logic      [SIZE_W-1:0] quo
);

	// The quotient is known to fit in SIZE_W bits, so the upper half of the
	// dividend starts out below the divisor.
	logic [SIZE_W-1:0] rem_s [1:SIZE_W-1];
	logic [SIZE_W-1:0] low_s [1:SIZE_W-1];
	logic [SIZE_W-1:0] quo_s [1:SIZE_W];

	for (genvar k = 1; k <= SIZE_W; k++) begin : g_step
		logic [SIZE_W-1:0] rem_i;
		logic [SIZE_W-1:0] low_i;
		logic [SIZE_W-1:0] quo_i;
		logic [SIZE_W:0]   trial;
		logic [SIZE_W+1:0] diff;
		logic              fits;

		if (k == 1) begin : g_first
			assign rem_i = num[PROD_W-1:SIZE_W];
			assign low_i = num[SIZE_W-1:0];
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign quo_i = quo_s[k-1];
		end

		assign trial = {rem_i, low_i[SIZE_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, den};
		assign fits  = ~diff[SIZE_W+1];

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_i[SIZE_W-2:0], fits};
			end
		end

		if (k < SIZE_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
					low_s[k] <= {low_i[SIZE_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[SIZE_W];

endmodule
`default_nettype wire

// ===== test/rcsp_checker.sv =====
// Checker for the rectangle clip, scale and pad block: predicts each result and compares it.
module rcsp_checker import rcsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_data,
	output int               errors,
	output int               pending
);

	logic signed [COORD_W-1:0] reg_rx, reg_ry;
	logic [SIZE_W-1:0] reg_rw, reg_rh, reg_sw, reg_sh;
	logic [PAD_W-1:0] reg_pad;
	out_t mapped_q[$];

	assign pending = mapped_q.size();

	// Clips one axis to the region, maps it to source pixels, then pads and clamps it to the source.
	function automatic bit map_axis(longint pos, longint len, longint rpos, longint rlen,
			longint src, longint padv, output longint o0, output longint olen);
		longint a0, a1, s0, s1;
		a0 = (pos > rpos) ? pos : rpos;
		a1 = (pos + len < rpos + rlen) ? pos + len : rpos + rlen;
		o0 = 0;
		olen = 0;
		if (a0 >= a1)
			return 0;
		s0 = ((a0 - rpos) * src) / rlen - padv;
		s1 = ((a1 - rpos) * src) / rlen + padv;
		if (s0 < 0)
			s0 = 0;
		if (s1 > src)
			s1 = src;
		if (s0 >= s1)
			return 0;
		o0 = s0;
		olen = s1 - s0;
		return 1;
	endfunction

	function automatic out_t map_rect(in_t r);
		out_t o;
		longint ox, oy, ow, oh;
		bit vx, vy;
		o = '0;
		if (reg_rw == 0 || reg_rh == 0 || reg_sw == 0 || reg_sh == 0 ||
				r.rect_w < 0 || r.rect_h < 0) begin
			o.status = ST_INVALID;
		end else begin
			vx = map_axis(r.rect_x, r.rect_w, reg_rx, reg_rw, reg_sw, reg_pad, ox, ow);
			vy = map_axis(r.rect_y, r.rect_h, reg_ry, reg_rh, reg_sh, reg_pad, oy, oh);
			if (vx && vy) begin
				o.status = ST_OK;
				o.out_x = ox[SIZE_W-1:0];
				o.out_y = oy[SIZE_W-1:0];
				o.out_w = ow[SIZE_W-1:0];
				o.out_h = oh[SIZE_W-1:0];
			end else begin
				o.status = ST_NOT_VISIBLE;
			end
		end
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			reg_rx <= '0; reg_ry <= '0; reg_rw <= '0; reg_rh <= '0;
			reg_sw <= '0; reg_sh <= '0; reg_pad <= '0;
			mapped_q.delete();
		end else begin
			if (in_valid && in_ready)
				mapped_q.push_back(map_rect(in_data));
			if (out_valid && out_ready) begin
				if (mapped_q.size() == 0) begin
					report("unexpected transaction", out_data.status, 0);
				end else begin
					want = mapped_q.pop_front();
					if (out_data.status !== want.status) report("status", out_data.status, want.status);
					if (out_data.out_x !== want.out_x) report("out_x", out_data.out_x, want.out_x);
					if (out_data.out_y !== want.out_y) report("out_y", out_data.out_y, want.out_y);
					if (out_data.out_w !== want.out_w) report("out_w", out_data.out_w, want.out_w);
					if (out_data.out_h !== want.out_h) report("out_h", out_data.out_h, want.out_h);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REGION_X: reg_rx <= cfg_data;
					REG_REGION_Y: reg_ry <= cfg_data;
					REG_REGION_W: reg_rw <= cfg_data[SIZE_W-1:0];
					REG_REGION_H: reg_rh <= cfg_data[SIZE_W-1:0];
					REG_SOURCE_W: reg_sw <= cfg_data[SIZE_W-1:0];
					REG_SOURCE_H: reg_sh <= cfg_data[SIZE_W-1:0];
					REG_PAD:      reg_pad <= cfg_data[PAD_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives configuration and rectangles into the block and gives the verdict.
module tb;
	import rcsp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;
	int errors, pending;
	int cycles = 0;
	bit long_hold = 0;
	bit hold_done = 0;

	localparam int LIMIT = 400000;

	rect_clip_scale_pad DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	rcsp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// The receiver stalls on its own pattern, with one long hold-off to fill the pipeline.
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 0;
		else if ((cycles / 300) % 3 == 0)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		repeat (200) @(posedge clk);
		wait (hold_done);
		@(posedge clk);
		long_hold <= 1;
		repeat (120) @(posedge clk);
		long_hold <= 0;
	end

	// The channel idles after each write before the task returns.
	task automatic write_reg(reg_idx_t idx, logic [COORD_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry,
			logic [COORD_W-1:0] rw, logic [COORD_W-1:0] rh, logic [COORD_W-1:0] sw,
			logic [COORD_W-1:0] sh, logic [COORD_W-1:0] pd);
		write_reg(REG_REGION_X, rx);
		write_reg(REG_REGION_Y, ry);
		write_reg(REG_REGION_W, rw);
		write_reg(REG_REGION_H, rh);
		write_reg(REG_SOURCE_W, sw);
		write_reg(REG_SOURCE_H, sh);
		write_reg(REG_PAD, pd);
	endtask

	// Sends one rectangle; valid stays high across back-to-back transactions when keep is set.
	task automatic send_rect(in_t r, bit keep);
		in_data <= r;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!keep)
			in_valid <= 0;
	endtask

	// Advances past the accepting edge first, so the checker has seen the last accepted transaction.
	task automatic drain;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rnd_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 24'h800000 + $urandom_range(0, 15);
			2: return 24'h7FFFFF - $urandom_range(0, 15);
			default: return $signed($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	// Rectangles mostly near the region so that many are visible.
	function automatic in_t rnd_rect(int cx, int cy, int span);
		in_t r;
		if ($urandom_range(0, 9) < 2) begin
			r.rect_x = rnd_coord();
			r.rect_y = rnd_coord();
			r.rect_w = rnd_coord();
			r.rect_h = rnd_coord();
		end else begin
			r.rect_x = cx + $signed($urandom_range(0, 2 * span)) - span;
			r.rect_y = cy + $signed($urandom_range(0, 2 * span)) - span;
			r.rect_w = $urandom_range(0, span);
			r.rect_h = $urandom_range(0, span);
			if ($urandom_range(0, 19) == 0)
				r.rect_w = -$signed($urandom_range(1, 100));
		end
		return r;
	endfunction

	task automatic random_phase(int count, int cx, int cy, int span);
		int sent = 0;
		int burst;
		int gap;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
			while (burst > 0 && sent < count) begin
				send_rect(rnd_rect(cx, cy, span),
					(burst > 1 || gap == 0) && sent + 1 < count);
				burst--;
				sent++;
			end
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Registers still at reset: every result is invalid.
		send_rect('{24'd0, 24'd0, 24'd256, 24'd256}, 0);
		drain();
		set_geometry(-24'sd1000, 24'd500, 24'd20000, 24'd10000, 24'd51200, 24'd25600, 24'd128);
		send_rect('{-24'sd1000, 24'd500, 24'd20000, 24'd10000}, 1);
		send_rect('{24'd5000, 24'd2000, 24'd300, 24'd400}, 1);
		send_rect('{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF}, 1);
		send_rect('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1);
		send_rect('{24'd0, 24'd600, 24'd0, 24'd100}, 1);
		send_rect('{24'd0, 24'd600, 24'h800000, 24'd100}, 1);
		send_rect('{24'd0, 24'd600, 24'd100, 24'hFFFFFF}, 1);
		send_rect('{-24'sd5000, 24'd600, 24'd100, 24'd100}, 1);
		send_rect('{24'd18999, 24'd10499, 24'd1, 24'd1}, 1);
		send_rect('{24'd19000, 24'd600, 24'd100, 24'd100}, 0);
		drain();
		// Zero padding and tiny sizes: a small rectangle maps to an empty one, the full region to one pixel.
		set_geometry(24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 24'd1, 24'd1, 24'd0);
		send_rect('{24'd0, 24'd0, 24'd5, 24'd5}, 1);
		send_rect('{24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF}, 0);
		drain();
		set_geometry(24'h800000, 24'h7FFFFF, 24'd1, 24'd1, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFF);
		send_rect('{24'h800000, 24'h7FFFFF, 24'd1, 24'd1}, 1);
		send_rect('{24'h800000, 24'h7FFFFF, 24'd0, 24'd0}, 0);
		drain();
		// Zero source height and an out-of-range index.
		set_geometry(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd8192, 24'd0, 24'hFFFFFF);
		write_reg(reg_idx_t'(3'd7), 24'hABCDEF);
		send_rect('{24'd0, 24'd0, 24'd100, 24'd100}, 0);
		drain();

		set_geometry(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd8192, 24'd2048, 24'd300);
		hold_done = 1;
		random_phase(700, 2048, 2048, 3000);
		drain();
		set_geometry(-24'sd40000, 24'd12345, 24'h7FFFFF, 24'd777, 24'd3, 24'h7FFFFF, 24'd0);
		random_phase(500, 0, 12345, 5000);
		drain();
		set_geometry($urandom, $urandom, $urandom_range(1, 24'h7FFFFF),
			$urandom_range(1, 24'h7FFFFF), $urandom_range(1, 24'h7FFFFF),
			$urandom_range(1, 24'h7FFFFF), $urandom);
		random_phase(300, 0, 0, 24'h3FFFFF);
		drain();
		set_geometry(24'd256, 24'd256, 24'd2560, 24'd1280, 24'd640, 24'd480, 24'd64);
		random_phase(400, 1500, 900, 2000);
		drain();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
